@@ sv/cmdp_pkg.sv @@
// Shared types and constants for the command frame parser.
package cmdp_pkg;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED  = 2'd0,
        STATUS_RESET_ACK = 2'd1,
        STATUS_WRONG_ID  = 2'd2,
        STATUS_MALFORMED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_RESET_COMMAND_CODE = 2'd0,
        CFG_ID_WINDOW          = 2'd1,
        CFG_ID_WRAP_VALUE      = 2'd2
    } cfg_index_t;

    localparam logic [7:0] ASCII_HASH  = 8'h23;
    localparam logic [7:0] ASCII_STAR  = 8'h2A;
    localparam logic [7:0] ASCII_COLON = 8'h3A;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;

    localparam logic [14:0] RESET_COMMAND_CODE_DEFAULT = 15'd0;
    localparam logic [14:0] ID_WINDOW_DEFAULT          = 15'd5;
    localparam logic [14:0] ID_WRAP_VALUE_DEFAULT      = 15'd99;

    localparam logic [15:0] FIELD_ABSENT = 16'hFFFF;
    localparam logic [16:0] LAST_ID_NONE = 17'h1FFFF;

    localparam int NUM_PARAMS = 5;

    typedef struct packed {
        logic [NUM_PARAMS-1:0][15:0] params;
        logic [2:0]                  field_count;
        logic [15:0]                 command;
        logic [15:0]                 ack_id;
        status_t                     status;
    } result_t;

endpackage

@@ sv/cmdp_core.sv @@
// Frame parsing state, field accumulation and sequence ID check for one byte per step.
module cmdp_core
    import cmdp_pkg::*;
#(
    parameter int MAX_FIELDS  = 6,
    parameter int FRAME_CHARS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    input  logic [14:0] reset_command_code,
    input  logic [14:0] id_window,
    input  logic [14:0] id_wrap_value,
    output logic        emit,
    output result_t     result
);

    localparam int IW = $clog2(MAX_FIELDS + 1);
    localparam int CW = $clog2(FRAME_CHARS + 1);

    logic                         frame_open_reg, frame_open_next;
    logic [CW-1:0]                char_count_reg, char_count_next;
    logic [15:0]                  accum_reg, accum_next;
    logic                         negative_reg, negative_next;
    logic                         stopped_reg, stopped_next;
    logic                         started_reg, started_next;
    logic [IW-1:0]                index_reg, index_next;
    logic                         too_many_reg, too_many_next;
    logic [MAX_FIELDS-1:0][15:0]  store_reg, store_next;
    logic [16:0]                  last_id_reg, last_id_next;

    logic [15:0]   commit_value;
    logic [18:0]   accum_prod;
    logic [15:0]   accum_digit;
    logic          is_digit;
    logic          has_room;
    logic [CW-1:0] char_count_inc;
    logic          well_formed;
    logic [15:0]   cmd_value;
    logic [NUM_PARAMS-1:0][15:0] param_value;
    logic [4:0]    count_wide;
    logic [17:0]   id_diff;
    logic          in_window;
    logic          cmd_is_reset;
    logic          ack_is_wrap;

    always_comb
    begin
        if (negative_reg)
        begin
            commit_value = ~accum_reg + 16'd1;
        end
        else if (accum_reg[15])
        begin
            commit_value = 16'h7FFF;
        end
        else
        begin
            commit_value = accum_reg;
        end
    end

    assign accum_prod  = 19'({accum_reg, 3'b000}) + 19'({accum_reg, 1'b0}) + 19'(rx_byte[3:0]);
    assign accum_digit = (accum_prod > 19'd32768) ? 16'h8000 : accum_prod[15:0];
    assign is_digit    = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
    assign has_room    = index_reg < IW'(MAX_FIELDS);

    assign char_count_inc = (char_count_reg == CW'(FRAME_CHARS)) ?
                            char_count_reg : char_count_reg + CW'(1);

    assign well_formed = frame_open_reg && !too_many_reg && has_room &&
                         (char_count_inc < CW'(FRAME_CHARS));

    assign cmd_value  = (index_reg == '0) ? commit_value : store_reg[0];
    assign count_wide = 5'(index_reg) + 5'd1;

    genvar k;
    generate
        for (k = 0; k < NUM_PARAMS; k++)
        begin : g_param
            if (k + 1 < MAX_FIELDS)
            begin : g_present
                assign param_value[k] = (index_reg == IW'(k + 1)) ?
                                        commit_value : store_reg[k+1];
            end
            else
            begin : g_absent
                assign param_value[k] = FIELD_ABSENT;
            end
        end
    endgenerate

    assign id_diff      = {{2{commit_value[15]}}, commit_value} - {last_id_reg[16], last_id_reg};
    assign in_window    = !id_diff[17] && (id_diff != '0) && (id_diff < {3'b000, id_window});
    assign cmd_is_reset = cmd_value == {1'b0, reset_command_code};
    assign ack_is_wrap  = commit_value == {1'b0, id_wrap_value};

    assign emit = step && (rx_byte == ASCII_STAR);

    always_comb
    begin
        result.params      = {NUM_PARAMS{FIELD_ABSENT}};
        result.field_count = 3'd0;
        result.command     = 16'd0;
        result.ack_id      = 16'd0;
        result.status      = STATUS_MALFORMED;
        if (well_formed)
        begin
            result.params      = param_value;
            result.field_count = count_wide[2:0];
            result.command     = cmd_value;
            result.ack_id      = commit_value;
            if (cmd_is_reset)
            begin
                result.status = STATUS_RESET_ACK;
            end
            else if (in_window)
            begin
                result.status = STATUS_ACCEPTED;
            end
            else
            begin
                result.status = STATUS_WRONG_ID;
            end
        end
    end

    always_comb
    begin
        frame_open_next = frame_open_reg;
        char_count_next = char_count_reg;
        accum_next      = accum_reg;
        negative_next   = negative_reg;
        stopped_next    = stopped_reg;
        started_next    = started_reg;
        index_next      = index_reg;
        too_many_next   = too_many_reg;
        store_next      = store_reg;
        last_id_next    = last_id_reg;
        if (step)
        begin
            if (rx_byte == ASCII_HASH)
            begin
                frame_open_next = 1'b1;
                char_count_next = CW'(1);
                index_next      = '0;
                too_many_next   = 1'b0;
                accum_next      = '0;
                negative_next   = 1'b0;
                stopped_next    = 1'b0;
                started_next    = 1'b0;
                store_next      = {MAX_FIELDS{FIELD_ABSENT}};
            end
            else if (rx_byte == ASCII_STAR)
            begin
                if (well_formed)
                begin
                    if (cmd_is_reset)
                    begin
                        last_id_next = LAST_ID_NONE;
                    end
                    else if (in_window)
                    begin
                        last_id_next = ack_is_wrap ? LAST_ID_NONE :
                                       {commit_value[15], commit_value};
                    end
                end
                frame_open_next = 1'b0;
                char_count_next = '0;
                index_next      = '0;
                too_many_next   = 1'b0;
                accum_next      = '0;
                negative_next   = 1'b0;
                stopped_next    = 1'b0;
                started_next    = 1'b0;
            end
            else if (frame_open_reg)
            begin
                char_count_next = char_count_inc;
                if (rx_byte == ASCII_COLON)
                begin
                    if (has_room)
                    begin
                        store_next[index_reg] = commit_value;
                        index_next            = index_reg + IW'(1);
                    end
                    else
                    begin
                        too_many_next = 1'b1;
                    end
                    accum_next    = '0;
                    negative_next = 1'b0;
                    stopped_next  = 1'b0;
                    started_next  = 1'b0;
                end
                else if (!stopped_reg)
                begin
                    if (is_digit)
                    begin
                        accum_next = accum_digit;
                    end
                    else if ((rx_byte == ASCII_MINUS) && !started_reg)
                    begin
                        negative_next = 1'b1;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                    started_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            char_count_reg <= '0;
            accum_reg      <= '0;
            negative_reg   <= 1'b0;
            stopped_reg    <= 1'b0;
            started_reg    <= 1'b0;
            index_reg      <= '0;
            too_many_reg   <= 1'b0;
            store_reg      <= {MAX_FIELDS{FIELD_ABSENT}};
            last_id_reg    <= LAST_ID_NONE;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            char_count_reg <= char_count_next;
            accum_reg      <= accum_next;
            negative_reg   <= negative_next;
            stopped_reg    <= stopped_next;
            started_reg    <= started_next;
            index_reg      <= index_next;
            too_many_reg   <= too_many_next;
            store_reg      <= store_next;
            last_id_reg    <= last_id_next;
        end
    end

    a_last_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        !last_id_reg[16] || (last_id_reg == LAST_ID_NONE))
        else $error("Stored last ID fell below minus one.");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= IW'(MAX_FIELDS))
        else $error("Field index ran past the field store.");

    a_closed_frame_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> (char_count_reg == '0) && (index_reg == '0) && !too_many_reg)
        else $error("Frame state left behind after the frame closed.");

endmodule

@@ sv/command_frame_parser_with_id_check_top.sv @@
// Top level of the command frame parser with sequence ID check.
//
//  Channel    Direction  Request carries
//  s_axis     in         one received ASCII byte
//  m_axis     out        status and parsed fields, one per '*' byte
//  cfg        in         register index and 15-bit write data
//
// Each byte is registered on acceptance and parsed from that register, so a new byte can
// be taken every cycle unless a '*' byte is held by a stalled result; the result is
// written to the output register when its '*' byte is parsed. Reset clears the frame
// state and sets the last ID to minus one and the registers to their defaults. A stalled
// result holds only a following '*' byte; other bytes keep flowing.
module command_frame_parser_with_id_check_top
    import cmdp_pkg::*;
#(
    parameter int MAX_FIELDS  = 6,
    parameter int FRAME_CHARS = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,   // status, ack_id, command, field_count,
                                         // param_1 .. param_5, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    result_t     out_result_reg;
    logic [14:0] reset_code_reg;
    logic [14:0] window_reg;
    logic [14:0] wrap_reg;
    logic        advance;
    logic        emit;
    result_t     result;

    assign advance = in_valid_reg &&
                     ((in_byte_reg != ASCII_STAR) || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    cmdp_core #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FRAME_CHARS (FRAME_CHARS)
    ) u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .rx_byte            (in_byte_reg),
        .reset_command_code (reset_code_reg),
        .id_window          (window_reg),
        .id_wrap_value      (wrap_reg),
        .emit               (emit),
        .result             (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_code_reg <= RESET_COMMAND_CODE_DEFAULT;
            window_reg     <= ID_WINDOW_DEFAULT;
            wrap_reg       <= ID_WRAP_VALUE_DEFAULT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RESET_COMMAND_CODE: reset_code_reg <= cfg_data[14:0];
                CFG_ID_WINDOW:          window_reg     <= cfg_data[14:0];
                CFG_ID_WRAP_VALUE:      wrap_reg       <= cfg_data[14:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_result_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_result_reg};

    a_result_follows_star: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && (in_byte_reg == ASCII_STAR)))
        else $error("Result raised without a parsed end-of-frame byte.");

    a_malformed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_result_reg.status == STATUS_MALFORMED) |->
        (out_result_reg.field_count == 3'd0) && (out_result_reg.command == 16'd0) &&
        (out_result_reg.ack_id == 16'd0))
        else $error("Malformed frame result carries field data.");

    a_stall_only_on_star: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && (in_byte_reg == ASCII_STAR) && out_valid_reg)
        else $error("Input stalled without a blocked end-of-frame byte.");

endmodule

@@ tb/sv/cmdp_frame_checker.sv @@
// Checker that predicts the parser results from the observed channels and compares them.
module cmdp_frame_checker
    import cmdp_pkg::*;
#(
    parameter int MAX_FIELDS  = 6,
    parameter int FRAME_CHARS = 20
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           error_count,
    output int           replies_pending
);

    logic [14:0] code_reg;
    logic [14:0] window_reg;
    logic [14:0] wrap_reg;

    logic        frame_active;
    int unsigned byte_count;
    int unsigned digit_accum;
    logic        value_negative;
    logic        value_ended;
    logic        value_begun;
    int unsigned fields_seen;
    logic        field_overflow;
    int          field_values[MAX_FIELDS];
    int          accepted_id;

    result_t     expected_replies[$];

    task automatic clear_field_state();
        digit_accum    = 0;
        value_negative = 1'b0;
        value_ended    = 1'b0;
        value_begun    = 1'b0;
    endtask

    task automatic clear_field_values();
        int k;
        for (k = 0; k < MAX_FIELDS; k++)
        begin
            field_values[k] = -1;
        end
    endtask

    task automatic reset_model();
        code_reg       = RESET_COMMAND_CODE_DEFAULT;
        window_reg     = ID_WINDOW_DEFAULT;
        wrap_reg       = ID_WRAP_VALUE_DEFAULT;
        frame_active   = 1'b0;
        byte_count     = 0;
        fields_seen    = 0;
        field_overflow = 1'b0;
        accepted_id    = -1;
        error_count    = 0;
        clear_field_state();
        clear_field_values();
        expected_replies.delete();
    endtask

    task automatic store_field();
        int v;
        if (value_negative)
        begin
            v = -int'(digit_accum);
        end
        else
        begin
            v = (digit_accum > 32767) ? 32767 : int'(digit_accum);
        end
        if (fields_seen < MAX_FIELDS)
        begin
            field_values[fields_seen] = v;
            fields_seen++;
        end
        else
        begin
            field_overflow = 1'b1;
        end
        clear_field_state();
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        result_t r;
        int      cmd;
        int      ack;
        int      k;
        if (b == ASCII_HASH)
        begin
            frame_active   = 1'b1;
            byte_count     = 1;
            fields_seen    = 0;
            field_overflow = 1'b0;
            clear_field_state();
            clear_field_values();
        end
        else if (b != ASCII_STAR)
        begin
            if (frame_active)
            begin
                if (byte_count < FRAME_CHARS)
                begin
                    byte_count++;
                end
                if (b == ASCII_COLON)
                begin
                    store_field();
                end
                else if (!value_ended)
                begin
                    if (b >= ASCII_ZERO && b <= ASCII_NINE)
                    begin
                        digit_accum = digit_accum * 10 + (b - ASCII_ZERO);
                        if (digit_accum > 32768)
                        begin
                            digit_accum = 32768;
                        end
                    end
                    else if (b == ASCII_MINUS && !value_begun)
                    begin
                        value_negative = 1'b1;
                    end
                    else
                    begin
                        value_ended = 1'b1;
                    end
                    value_begun = 1'b1;
                end
            end
        end
        else
        begin
            r.status      = STATUS_MALFORMED;
            r.ack_id      = '0;
            r.command     = '0;
            r.field_count = '0;
            for (k = 0; k < NUM_PARAMS; k++)
            begin
                r.params[k] = FIELD_ABSENT;
            end
            if (frame_active)
            begin
                if (byte_count < FRAME_CHARS)
                begin
                    byte_count++;
                end
                store_field();
                if (!field_overflow && byte_count <= FRAME_CHARS - 1 && fields_seen > 0)
                begin
                    cmd           = field_values[0];
                    ack           = field_values[fields_seen - 1];
                    r.field_count = 3'(fields_seen);
                    r.command     = cmd[15:0];
                    r.ack_id      = ack[15:0];
                    for (k = 0; k < NUM_PARAMS; k++)
                    begin
                        if (k + 1 < MAX_FIELDS)
                        begin
                            r.params[k] = field_values[k + 1][15:0];
                        end
                    end
                    if (cmd == int'(code_reg))
                    begin
                        accepted_id = -1;
                        r.status    = STATUS_RESET_ACK;
                    end
                    else if (ack > accepted_id && ack - accepted_id < int'(window_reg))
                    begin
                        accepted_id = (ack == int'(wrap_reg)) ? -1 : ack;
                        r.status    = STATUS_ACCEPTED;
                    end
                    else
                    begin
                        r.status = STATUS_WRONG_ID;
                    end
                end
            end
            frame_active   = 1'b0;
            byte_count     = 0;
            fields_seen    = 0;
            field_overflow = 1'b0;
            clear_field_state();
            expected_replies.push_back(r);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_reply(input result_t got);
        result_t want;
        int      k;
        if (expected_replies.size() == 0)
        begin
            $error("result with no request pending");
            error_count++;
        end
        else
        begin
            want = expected_replies.pop_front();
            compare_field("status", int'(want.status), int'(got.status));
            compare_field("ack_id", $signed(want.ack_id), $signed(got.ack_id));
            compare_field("command", $signed(want.command), $signed(got.command));
            compare_field("field_count", want.field_count, got.field_count);
            for (k = 0; k < NUM_PARAMS; k++)
            begin
                compare_field($sformatf("param_%0d", k + 1),
                              $signed(want.params[k]), $signed(got.params[k]));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_model();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_RESET_COMMAND_CODE: code_reg   = cfg_data[14:0];
                    CFG_ID_WINDOW:          window_reg = cfg_data[14:0];
                    CFG_ID_WRAP_VALUE:      wrap_reg   = cfg_data[14:0];
                    default:                ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                check_reply(result_t'(m_tdata[$bits(result_t)-1:0]));
            end
            if (s_tvalid && s_tready)
            begin
                parse_rx_byte(s_tdata);
            end
        end
        replies_pending = expected_replies.size();
    end

endmodule

@@ tb/sv/command_frame_parser_with_id_check_top_test.sv @@
// Testbench top: drives command frames and configuration into the parser and gives the verdict.
module command_frame_parser_with_id_check_top_test
    import cmdp_pkg::*;
();

    localparam int MAX_FIELDS  = 6;
    localparam int FRAME_CHARS = 20;
    localparam int PHASE_BYTES = 250;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;

    int           error_count;
    int           replies_pending;
    int           bytes_sent;
    logic         calm;
    logic [7:0]   frame_bytes[$];
    int           next_id;
    int           code_now;
    int           window_now;
    int           wrap_now;

    assign calm = (bytes_sent >= 800) && (bytes_sent < 1100);

    always #10 clk = ~clk;

    command_frame_parser_with_id_check_top #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FRAME_CHARS (FRAME_CHARS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    cmdp_frame_checker #(
        .MAX_FIELDS  (MAX_FIELDS),
        .FRAME_CHARS (FRAME_CHARS)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_axis_tvalid),
        .s_tready        (s_axis_tready),
        .s_tdata         (s_axis_tdata),
        .m_tvalid        (m_axis_tvalid),
        .m_tready        (m_axis_tready),
        .m_tdata         (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .replies_pending (replies_pending)
    );

    task automatic put_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 29)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            put_byte(s[i]);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (replies_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input int value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = {1'b0, 15'(value)};
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic configure(input int code, input int window, input int wrap);
        write_register(CFG_RESET_COMMAND_CODE, code);
        write_register(CFG_ID_WINDOW, window);
        write_register(CFG_ID_WRAP_VALUE, wrap);
        cfg_valid  = 1'b0;
        code_now   = code;
        window_now = window;
        wrap_now   = wrap;
    endtask

    function automatic int pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return $urandom_range(9);
        if (sel < 65)
            return int'($urandom_range(120)) - 20;
        if (sel < 85)
            return $urandom_range(32767);
        if (sel < 93)
            return $urandom_range(99999, 32768);
        return -int'($urandom_range(40000));
    endfunction

    task automatic push_number(input int v);
        string s;
        int    i;
        s = $sformatf("%0d", v);
        for (i = 0; i < s.len(); i++)
        begin
            frame_bytes.push_back(s[i]);
        end
    endtask

    task automatic build_random_frame();
        int kind;
        int cmd;
        int ident;
        int nparams;
        int k;
        frame_bytes.delete();
        kind = $urandom_range(99);
        if (kind >= 85)
        begin
            repeat ($urandom_range(4, 1)) frame_bytes.push_back(8'($urandom_range(255)));
            return;
        end
        frame_bytes.push_back(ASCII_HASH);
        cmd = ($urandom_range(99) < 20) ? code_now : pick_value();
        push_number(cmd);
        nparams = (kind >= 70) ? $urandom_range(7) : $urandom_range(4);
        for (k = 0; k < nparams; k++)
        begin
            frame_bytes.push_back(ASCII_COLON);
            push_number(($urandom_range(99) < 70) ? int'($urandom_range(30)) - 5 : pick_value());
        end
        ident = cmd;
        if ($urandom_range(99) >= 10)
        begin
            ident = ($urandom_range(99) < 75) ? next_id : pick_value();
            frame_bytes.push_back(ASCII_COLON);
            push_number(ident);
        end
        if (kind >= 70)
        begin
            case ($urandom_range(2))
                0: frame_bytes.insert($urandom_range(frame_bytes.size()),
                                      8'($urandom_range(255)));
                1: frame_bytes.insert($urandom_range(frame_bytes.size(), 1), ASCII_MINUS);
                default: frame_bytes.delete(0);
            endcase
        end
        frame_bytes.push_back(ASCII_STAR);
        if (kind < 70)
        begin
            if (cmd == code_now)
                next_id = 0;
            else if (ident == next_id)
                next_id = (ident == wrap_now) ? 0 : ident + 1;
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a stall-free stretch.
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else if (!hold_done && bytes_sent >= 400)
            begin
                hold_done     = 1'b1;
                hold_left     = 120;
                m_axis_tready = 1'b0;
            end
            else
            begin
                m_axis_tready = calm || ($urandom_range(99) >= 29);
            end
        end
    end

    initial
    begin
        int phase;
        int phase_end;
        int i;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_RESET_COMMAND_CODE;
        cfg_data      = '0;
        bytes_sent    = 0;
        next_id       = 0;
        code_now      = RESET_COMMAND_CODE_DEFAULT;
        window_now    = ID_WINDOW_DEFAULT;
        wrap_now      = ID_WRAP_VALUE_DEFAULT;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_text("*");
        put_byte(8'hFF);
        send_text("x#0*");
        send_text("#1:0*#1:0*");
        send_text("#-5:--5:1*");
        send_text("#99999:-99999:2*");
        send_text("#1:2:3:4:5:6:7*");
        send_text("#1:2:3:4:5:3*");
        send_text("#12345678901234567890*");
        send_text("#5:9#1::4*");
        send_text("#1:a7:");
        put_byte(8'h00);
        send_text("9:5x*");
        send_text("#*#19:*");
        drain_results();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: ;
                1: configure(32767, 32767, 32767);
                2: configure(0, 2, 0);
                3: configure(7, 3, 4);
                4: configure(12345, 1, $urandom_range(32767));
                default: configure($urandom_range(20), $urandom_range(10, 1),
                                   $urandom_range(30));
            endcase
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end)
            begin
                build_random_frame();
                for (i = 0; i < frame_bytes.size(); i++)
                begin
                    put_byte(frame_bytes[i]);
                end
            end
            drain_results();
        end

        if (error_count == 0)
            $display("command_frame_parser_with_id_check_top_test: done, clean");
        else
            $display("command_frame_parser_with_id_check_top_test: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("command_frame_parser_with_id_check_top_test: done, errors");
        $finish;
    end

endmodule
